/* hdl/array_priority_queue_macros.svh */
// assertion macros for the array priority queue
`ifndef ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define APQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("array_priority_queue assertion failed");

// next-cycle implication, checked outside reset
`define APQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("array_priority_queue assertion failed");

`endif

/* hdl/apq_pkg.sv */
// types and constants shared by the array priority queue modules
package apq_pkg;

   localparam int DEPTH         = 8;
   localparam int PRIORITY_BITS = 8;

   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 4;

   localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] entry_value;
      logic [PRIO_W-1:0]         entry_priority;
   } apq_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] out_value;
      logic [PRIO_W-1:0]         out_priority;
      logic [FILL_W-1:0]         fill_count;
   } apq_rsp_type;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [VALUE_W-1:0]       value;
   } apq_entry_type;

   typedef struct packed {
      logic start;
      logic rsp_free;
   } apq_core_in_type;

   typedef struct packed {
      logic idle;
      logic done;
   } apq_core_out_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } apq_state_type;

endpackage

/* hdl/apq_core.sv */
// sequencer and entry memory: scan for the maximum; dequeue shifts entries down
module apq_core import apq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  apq_core_in_type  ctl_in,
   input  apq_req_type      req_data,
   output apq_core_out_type ctl_out,
   output apq_rsp_type      result
);

   apq_entry_type mem [DEPTH];
   apq_entry_type rd_data_ff;

   apq_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             op_deq_ff, op_deq_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   apq_entry_type    best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   apq_rsp_type      res_ff, res_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   apq_entry_type    mem_wd;
   logic             mem_re;
   logic [IDX_W-1:0] mem_ra;

   logic issue;
   logic is_full;
   logic is_empty;
   logic idx_end;

   assign issue    = idx_ff < count_ff;
   assign idx_end  = idx_ff == count_ff;
   assign is_full  = count_ff == CNT_W'(DEPTH);
   assign is_empty = count_ff == '0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl_in.start) begin
               if ((req_data.action == ACT_DEQUEUE || req_data.action == ACT_PEEK)
                   && !is_empty) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (idx_end) begin
               state_in = op_deq_ff ? ST_SHIFT : ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (idx_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ctl_in.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory controls and handshake toward the top level
   always_comb begin
      ctl_out.idle = state_ff == ST_IDLE;
      ctl_out.done = (state_ff == ST_DONE) && ctl_in.rsp_free;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = rd_data_ff;
      mem_re = 1'b0;
      mem_ra = idx_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (ctl_in.start && req_data.action == ACT_ENQUEUE && !is_full) begin
               mem_we       = 1'b1;
               mem_wa       = count_ff[IDX_W-1:0];
               mem_wd.prio  = PRIORITY_BITS'(req_data.entry_priority);
               mem_wd.value = req_data.entry_value;
            end
         end
         ST_SCAN: begin
            mem_re = issue;
         end
         ST_SHIFT: begin
            // read address runs two slots ahead of the write, so they never collide
            mem_re = issue;
            mem_we = rd_valid_ff;
            mem_wa = rd_idx_ff - IDX_W'(1);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in    = count_ff;
      idx_in      = idx_ff;
      op_deq_in   = op_deq_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = idx_ff[IDX_W-1:0];
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      res_in      = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl_in.start) begin
               res_in.status       = STATUS_OK;
               res_in.out_value    = '0;
               res_in.out_priority = '0;
               idx_in              = '0;
               op_deq_in           = req_data.action == ACT_DEQUEUE;
               case (req_data.action)
                  ACT_ENQUEUE: begin
                     if (is_full) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_DEQUEUE, ACT_PEEK: begin
                     if (is_empty) begin
                        res_in.status = STATUS_EMPTY;
                     end
                  end
                  default: begin
                     res_in.status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_valid_in = issue;
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            // strict compare keeps the oldest entry among equal priorities
            if (rd_valid_ff && (rd_idx_ff == '0 || rd_data_ff.prio > best_ff.prio)) begin
               best_in     = rd_data_ff;
               best_idx_in = rd_idx_ff;
            end
            if (idx_end) begin
               res_in.out_priority = PRIO_W'(best_in.prio);
               if (op_deq_ff) begin
                  res_in.out_value = best_in.value;
                  idx_in           = CNT_W'(best_idx_in) + CNT_W'(1);
               end
            end
         end
         ST_SHIFT: begin
            rd_valid_in = issue;
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (idx_end) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            rd_valid_in = 1'b0;
         end
      endcase
      res_in.fill_count = FILL_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      op_deq_ff   <= op_deq_in;
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      res_ff      <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   assign result = res_ff;

endmodule

/* hdl/array_priority_queue.sv */
// Bounded priority queue of DEPTH (value, priority) pairs kept in arrival order in one
// memory with a registered read. One transaction is worked at a time. Enqueue, a
// dequeue or peek on an empty queue, and the unused action code go straight to a
// result with no scan. A peek or a dequeue otherwise uses the single memory read
// port: it visits each held entry once to find the maximum priority, and a dequeue
// then visits each entry younger than the one removed once more to shift it down a
// slot. A finished result sits in an output register, so the next request is
// accepted while the previous response still waits for rsp_ready.
`include "array_priority_queue_macros.svh"

module array_priority_queue import apq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  apq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output apq_rsp_type rsp_data
);

   apq_core_in_type  core_in;
   apq_core_out_type core_out;
   apq_rsp_type      core_result;

   logic        rsp_valid_ff, rsp_valid_in;
   apq_rsp_type rsp_data_ff;

   assign req_ready        = core_out.idle;
   assign core_in.start    = req_valid && req_ready;
   assign core_in.rsp_free = !rsp_valid_ff || rsp_ready;

   apq_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (core_in),
      .req_data (req_data),
      .ctl_out  (core_out),
      .result   (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_out.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_out.done) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a full report only comes with a full queue
   `APQ_ASSERT_NOW(a_full_count, rsp_valid && rsp_data.status == STATUS_FULL, rsp_data.fill_count == FILL_W'(DEPTH))
   // an empty report carries no entry and no count
   `APQ_ASSERT_NOW(a_empty_zero, rsp_valid && rsp_data.status == STATUS_EMPTY, rsp_data.fill_count == '0 && rsp_data.out_value == '0 && rsp_data.out_priority == '0)
   // the core never overwrites a response still waiting to be taken
   `APQ_ASSERT_NOW(a_no_overwrite, core_out.done, !rsp_valid_ff || rsp_ready)
   // a finished transaction is always presented next cycle
   `APQ_ASSERT_NEXT(a_done_shows, core_out.done, rsp_valid)

endmodule

/* tb/tb_array_priority_queue.sv */
// self-checking testbench for the array priority queue
`timescale 1ns / 1ps

module tb_array_priority_queue;
   import apq_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam int RANDOM_OPS   = 1250;
   localparam int PHASE_LEN    = 425;
   localparam int HOLD_CYCLES  = 160;
   localparam int HOLD_SPACING = 450;
   localparam int DRAIN_CYCLES = 40;
   localparam int RESET_CYCLES = 11;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   apq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   apq_rsp_type rsp_data;

   // shadow copy of the queue contents, oldest entry in slot 0
   logic [VALUE_W-1:0] shadow_vals  [DEPTH];
   logic [PRIO_W-1:0]  shadow_prios [DEPTH];
   int                 shadow_count = 0;

   apq_req_type op_requests_q[$];
   apq_rsp_type op_results_q[$];

   int sent_count    = 0;
   int rsp_count     = 0;
   int useful_ops    = 0;
   int error_count   = 0;
   int hold_left     = 0;
   int next_hold_at  = 120;
   int tx_idle_pct;
   int rx_idle_pct;

   array_priority_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // idle mix by phase: sender light/receiver heavy, then swapped, then none
   always_comb begin
      if (sent_count < PHASE_LEN) begin
         tx_idle_pct = 14;
         rx_idle_pct = 60;
      end else if (sent_count < 2 * PHASE_LEN) begin
         tx_idle_pct = 60;
         rx_idle_pct = 14;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   end

   // applies one operation to the shadow queue and returns the response it yields
   function automatic apq_rsp_type apply_queue_op(apq_req_type op);
      apq_rsp_type        res;
      logic [PRIO_W-1:0]  top_prio;
      int                 pos;
      res = '0;
      case (op.action)
         ACT_ENQUEUE: begin
            if (shadow_count >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               shadow_vals[shadow_count]  = op.entry_value;
               shadow_prios[shadow_count] = op.entry_priority;
               shadow_count++;
            end
         end
         ACT_DEQUEUE, ACT_PEEK: begin
            if (shadow_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               top_prio = '0;
               for (int k = 0; k < shadow_count; k++)
                  if (shadow_prios[k] > top_prio) top_prio = shadow_prios[k];
               res.out_priority = top_prio;
               if (op.action == ACT_DEQUEUE) begin
                  // oldest entry holding the top priority wins
                  pos = 0;
                  while (shadow_prios[pos] != top_prio) pos++;
                  res.out_value = shadow_vals[pos];
                  for (int k = pos; k + 1 < shadow_count; k++) begin
                     shadow_vals[k]  = shadow_vals[k + 1];
                     shadow_prios[k] = shadow_prios[k + 1];
                  end
                  shadow_count--;
               end
            end
         end
         default: ;
      endcase
      res.fill_count = FILL_W'(shadow_count);
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("ERROR response %0d: %s got %0d expected %0d", rsp_count, field, got, want);
      error_count++;
   endtask

   task automatic add_op(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                         logic [PRIO_W-1:0] prio);
      apq_req_type op;
      op.action         = act;
      op.entry_value    = val;
      op.entry_priority = prio;
      op_requests_q.push_back(op);
      if (act != ACT_UNUSED) useful_ops++;
   endtask

   function automatic logic [PRIO_W-1:0] pick_prio(int mode);
      logic [PRIO_W-1:0] p;
      case (mode)
         0: p = PRIO_W'($urandom_range(3));
         1: begin
            case ($urandom_range(3))
               0: p = '0;
               1: p = '1;
               2: p = 8'd1;
               default: p = 8'd254;
            endcase
         end
         default: p = PRIO_W'($urandom);
      endcase
      return p;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            op_results_q.push_back(apply_queue_op(req_data));
            sent_count <= sent_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (op_requests_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_data  <= op_requests_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver with periodic long hold-off to back the queue up into the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (rsp_count >= next_hold_at) begin
         rsp_ready    <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + HOLD_SPACING;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      apq_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (op_results_q.size() == 0) begin
            // transaction with nothing expected
            report_mismatch("pending", 0, 1);
         end else begin
            want = op_results_q.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.out_value !== want.out_value)
               report_mismatch("out_value", rsp_data.out_value, want.out_value);
            if (rsp_data.out_priority !== want.out_priority)
               report_mismatch("out_priority", rsp_data.out_priority, want.out_priority);
            if (rsp_data.fill_count !== want.fill_count)
               report_mismatch("fill_count", rsp_data.fill_count, want.fill_count);
         end
         rsp_count <= rsp_count + 1;
      end
   end

   initial begin
      int kind;
      int len;
      int mode;
      int roll;

      // empty queue corners
      add_op(ACT_DEQUEUE, 32'h0000_0000, 8'd0);
      add_op(ACT_PEEK, 32'hffff_ffff, 8'hff);
      add_op(ACT_UNUSED, 32'h1111_1111, 8'd3);
      // fill with extreme values, ties at the top and at zero priority
      add_op(ACT_ENQUEUE, 32'h8000_0000, 8'd0);
      add_op(ACT_ENQUEUE, 32'h7fff_ffff, 8'd255);
      add_op(ACT_ENQUEUE, 32'h0000_0000, 8'd17);
      add_op(ACT_ENQUEUE, 32'hffff_ffff, 8'd255);
      add_op(ACT_ENQUEUE, 32'h1234_5678, 8'd0);
      add_op(ACT_ENQUEUE, 32'h5a5a_a5a5, 8'd128);
      add_op(ACT_ENQUEUE, 32'ha5a5_5a5a, 8'd255);
      add_op(ACT_ENQUEUE, 32'h0000_0001, 8'd1);
      // full queue drops the entry
      add_op(ACT_ENQUEUE, 32'hdead_beef, 8'd200);
      add_op(ACT_PEEK, 32'h0, 8'd0);
      add_op(ACT_UNUSED, 32'h0, 8'd0);
      // drain in priority order, oldest first among ties
      for (int k = 0; k < DEPTH; k++)
         add_op(ACT_DEQUEUE, $urandom, PRIO_W'($urandom));
      add_op(ACT_DEQUEUE, 32'h0, 8'd0);

      useful_ops = 0;
      while (useful_ops < RANDOM_OPS) begin
         kind = $urandom_range(9);
         mode = $urandom_range(2);
         len  = $urandom_range(3, 11);
         if (kind <= 3) begin
            // fill burst, often past full
            for (int k = 0; k < len; k++)
               add_op(ACT_ENQUEUE, $urandom, pick_prio(mode));
         end else if (kind <= 6) begin
            // drain burst with the odd peek, often past empty
            for (int k = 0; k < len; k++)
               add_op(($urandom_range(4) == 0) ? ACT_PEEK : ACT_DEQUEUE,
                      $urandom, PRIO_W'($urandom));
         end else if (kind <= 8) begin
            for (int k = 0; k < len; k++) begin
               roll = $urandom_range(99);
               if (roll < 42)
                  add_op(ACT_ENQUEUE, $urandom, pick_prio(mode));
               else if (roll < 77)
                  add_op(ACT_DEQUEUE, $urandom, PRIO_W'($urandom));
               else if (roll < 96)
                  add_op(ACT_PEEK, $urandom, PRIO_W'($urandom));
               else
                  add_op(ACT_UNUSED, $urandom, PRIO_W'($urandom));
            end
         end else begin
            add_op(ACTION_W'($urandom_range(3)), $urandom, PRIO_W'($urandom));
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (op_requests_q.size() != 0 || req_valid) @(posedge clock);
      while (op_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
